// ===== rtl/core/vmet_pkg.sv =====
`default_nettype none

package vmet_pkg;

    // Fixed widths of the external fields.
    localparam int THR_W    = 42;
    localparam int OUT_W    = 32;
    localparam int IN_W     = 32;
    localparam int GF_W     = 31;
    localparam int GAIN_W   = 10;
    localparam int GROWTH_W = 32;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [GROWTH_W-1:0] Q30_ONE    = 32'h4000_0000;
    localparam logic [GROWTH_W-1:0] Q30_HALF   = 32'h2000_0000;
    localparam logic [GF_W-1:0]     GF_RESET   = 31'd1073849198;
    localparam logic [GAIN_W-1:0]   GAIN_RESET = 10'd1000;

    // Register indexes, taken from paddr[2].
    localparam logic REG_GROWTH_FACTOR  = 1'b0;
    localparam logic REG_THRESHOLD_GAIN = 1'b1;

    // Multiplier operand selects.
    localparam logic [2:0] MUL_GROW    = 3'd0;
    localparam logic [2:0] MUL_MLO_G   = 3'd1;
    localparam logic [2:0] MUL_MHI_G   = 3'd2;
    localparam logic [2:0] MUL_MLO_MLO = 3'd3;
    localparam logic [2:0] MUL_MLO_MHI = 3'd4;
    localparam logic [2:0] MUL_MHI_MHI = 3'd5;

    // Accumulator operations on the registered product.
    localparam logic [2:0] ACC_HOLD     = 3'd0;
    localparam logic [2:0] ACC_LOAD     = 3'd1;
    localparam logic [2:0] ACC_ADD_SH32 = 3'd2;
    localparam logic [2:0] ACC_ADD_SH33 = 3'd3;
    localparam logic [2:0] ACC_ADD_SH64 = 3'd4;

    // Datapath operations.
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD_IN  = 4'd1;
    localparam logic [3:0] OP_FIRST    = 4'd2;
    localparam logic [3:0] OP_GROW     = 4'd3;
    localparam logic [3:0] OP_MIN      = 4'd4;
    localparam logic [3:0] OP_CMP      = 4'd5;
    localparam logic [3:0] OP_DIV_INIT = 4'd6;
    localparam logic [3:0] OP_DIV_STEP = 4'd7;
    localparam logic [3:0] OP_SUB      = 4'd8;
    localparam logic [3:0] OP_GAIN     = 4'd9;
    localparam logic [3:0] OP_OUT      = 4'd10;

    typedef struct packed {
        logic [2:0] mul_sel;
        logic [2:0] acc_op;
        logic [3:0] op;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/vad_min_max_energy_threshold.sv =====
// Adaptive energy threshold for voice activity detection (Emin/Emax tracker).
// Input channel: one frame energy per transfer with a first-frame flag, on
// i_in_valid / o_in_ready. Output channel: one result per input transfer on
// o_out_valid / i_out_ready, carrying the threshold and the tracked minimum
// and maximum energies. Configuration (growth factor, threshold gain) goes
// through the APB-style port and must only change while the block is idle.
// Flow: one item at a time; a new frame is taken only once the previous one
// has gone through the whole sequence. A first frame skips the growth update,
// the minimum update and the compare. The restoring divider for Emin^2 / Emax
// makes one quotient bit per cycle and develops ENERGY_BITS + 17 quotient
// bits; the shared 32x32 multiplier forms the growth and square products.
// The result sits in an output register, so a new frame is taken while the
// previous result still waits; a receiver that stalls holds the block only
// when a second result is ready to be written over the first.
// Reset (synchronous, active low) restores max 1, min 1.0, growth 1.0, a
// first value of 0 and the default configuration, and empties the output.
`default_nettype none

module vad_min_max_energy_threshold #(
    parameter int ENERGY_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [vmet_pkg::IN_W-1:0]     i_frame_energy,
    input  wire logic                          i_first_frame,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [vmet_pkg::THR_W-1:0]    o_threshold_out,
    output logic      [vmet_pkg::OUT_W-1:0]    o_min_energy_out,
    output logic      [vmet_pkg::OUT_W-1:0]    o_max_energy_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vmet_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [vmet_pkg::DATA_W-1:0]   pwdata,
    output logic      [vmet_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import vmet_pkg::*;

    t_dp_cmd           cmd;
    logic [GF_W-1:0]   growth_factor;
    logic [GAIN_W-1:0] threshold_gain;

    assign pready = 1'b1;

    vmet_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .o_growth_factor  (growth_factor),
        .o_threshold_gain (threshold_gain)
    );

    vmet_ctrl #(
        .ENERGY_BITS (ENERGY_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_first_frame (i_first_frame),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cmd         (cmd)
    );

    vmet_dp #(
        .ENERGY_BITS (ENERGY_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_frame_energy   (i_frame_energy),
        .i_growth_factor  (growth_factor),
        .i_threshold_gain (threshold_gain),
        .o_threshold_out  (o_threshold_out),
        .o_min_energy_out (o_min_energy_out),
        .o_max_energy_out (o_max_energy_out)
    );

endmodule

`default_nettype wire

// ===== rtl/core/vmet_regs.sv =====
`default_nettype none

module vmet_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vmet_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [vmet_pkg::DATA_W-1:0]   pwdata,
    output logic      [vmet_pkg::DATA_W-1:0]   prdata,
    output logic      [vmet_pkg::GF_W-1:0]     o_growth_factor,
    output logic      [vmet_pkg::GAIN_W-1:0]   o_threshold_gain
);
    import vmet_pkg::*;

    logic [GF_W-1:0]   r_growth_factor;
    logic [GAIN_W-1:0] r_threshold_gain;
    logic              wr_en;

    // pready is tied high, so the access phase always completes the transfer.
    assign wr_en = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_growth_factor  <= GF_RESET;
            r_threshold_gain <= GAIN_RESET;
        end else if (wr_en) begin
            case (paddr[ADDR_W-1])
                REG_GROWTH_FACTOR:  r_growth_factor  <= pwdata[GF_W-1:0];
                REG_THRESHOLD_GAIN: r_threshold_gain <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1])
            REG_GROWTH_FACTOR:  prdata = DATA_W'(r_growth_factor);
            REG_THRESHOLD_GAIN: prdata = DATA_W'(r_threshold_gain);
            default:            prdata = '0;
        endcase
    end

    assign o_growth_factor  = r_growth_factor;
    assign o_threshold_gain = r_threshold_gain;

endmodule

`default_nettype wire

// ===== rtl/core/vmet_ctrl.sv =====
`default_nettype none

module vmet_ctrl #(
    parameter int ENERGY_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_first_frame,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output vmet_pkg::t_dp_cmd      o_cmd
);
    import vmet_pkg::*;

    localparam int MB = ENERGY_BITS + 16;
    localparam int CW = $clog2(MB + 2);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_FIRST = 5'd1;
    localparam logic [4:0] S_GMUL  = 5'd2;
    localparam logic [4:0] S_GUPD  = 5'd3;
    localparam logic [4:0] S_MMUL0 = 5'd4;
    localparam logic [4:0] S_MMUL1 = 5'd5;
    localparam logic [4:0] S_MACC  = 5'd6;
    localparam logic [4:0] S_MUPD  = 5'd7;
    localparam logic [4:0] S_CMP   = 5'd8;
    localparam logic [4:0] S_SQ0   = 5'd9;
    localparam logic [4:0] S_SQ1   = 5'd10;
    localparam logic [4:0] S_SQ2   = 5'd11;
    localparam logic [4:0] S_SQ3   = 5'd12;
    localparam logic [4:0] S_DINIT = 5'd13;
    localparam logic [4:0] S_DIV   = 5'd14;
    localparam logic [4:0] S_SUB   = 5'd15;
    localparam logic [4:0] S_GAIN  = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    logic [4:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          load_out;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        load_out    = 1'b0;
        o_cmd       = '{mul_sel: MUL_GROW, acc_op: ACC_HOLD, op: OP_NONE};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD_IN;
                    n_state  = i_first_frame ? S_FIRST : S_GMUL;
                end
            end
            S_FIRST: begin
                o_cmd.op = OP_FIRST;
                n_state  = S_SQ0;
            end
            S_GMUL: begin
                o_cmd.mul_sel = MUL_GROW;
                n_state       = S_GUPD;
            end
            S_GUPD: begin
                o_cmd.op = OP_GROW;
                n_state  = S_MMUL0;
            end
            S_MMUL0: begin
                o_cmd.mul_sel = MUL_MLO_G;
                n_state       = S_MMUL1;
            end
            S_MMUL1: begin
                o_cmd.mul_sel = MUL_MHI_G;
                o_cmd.acc_op  = ACC_LOAD;
                n_state       = S_MACC;
            end
            S_MACC: begin
                o_cmd.acc_op = ACC_ADD_SH32;
                n_state      = S_MUPD;
            end
            S_MUPD: begin
                o_cmd.op = OP_MIN;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                n_state  = S_SQ0;
            end
            // The square is built from three partial products; the cross term
            // appears twice, so it is added once shifted by one more bit.
            S_SQ0: begin
                o_cmd.mul_sel = MUL_MLO_MLO;
                n_state       = S_SQ1;
            end
            S_SQ1: begin
                o_cmd.mul_sel = MUL_MLO_MHI;
                o_cmd.acc_op  = ACC_LOAD;
                n_state       = S_SQ2;
            end
            S_SQ2: begin
                o_cmd.mul_sel = MUL_MHI_MHI;
                o_cmd.acc_op  = ACC_ADD_SH33;
                n_state       = S_SQ3;
            end
            S_SQ3: begin
                o_cmd.acc_op = ACC_ADD_SH64;
                n_state      = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_cnt    = CW'(MB);
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_cnt == '0) begin
                    n_state = S_SUB;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SUB: begin
                o_cmd.op = OP_SUB;
                n_state  = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.op = OP_GAIN;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op = OP_OUT;
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/vmet_dp.sv =====
`default_nettype none

module vmet_dp #(
    parameter int ENERGY_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire vmet_pkg::t_dp_cmd             i_cmd,
    input  wire logic [vmet_pkg::IN_W-1:0]     i_frame_energy,
    input  wire logic [vmet_pkg::GF_W-1:0]     i_growth_factor,
    input  wire logic [vmet_pkg::GAIN_W-1:0]   i_threshold_gain,
    output logic      [vmet_pkg::THR_W-1:0]    o_threshold_out,
    output logic      [vmet_pkg::OUT_W-1:0]    o_min_energy_out,
    output logic      [vmet_pkg::OUT_W-1:0]    o_max_energy_out
);
    import vmet_pkg::*;

    localparam int EB = ENERGY_BITS;
    localparam int MB = ENERGY_BITS + 16;

    // Tracker state.
    logic [EB-1:0]       r_max, n_max;
    logic [MB-1:0]       r_min, n_min;
    logic [GROWTH_W-1:0] r_growth, n_growth;
    logic [EB-1:0]       r_fv, n_fv;

    // Work registers.
    logic [EB-1:0]       r_e;
    logic [63:0]         r_prod;
    logic [127:0]        r_acc;
    logic [MB-1:0]       r_rem;
    logic [MB:0]         r_quo;
    logic                r_ovf;
    logic [MB:0]         r_t;
    logic [THR_W-1:0]    r_thr;
    logic [THR_W-1:0]    r_thr_out;
    logic [OUT_W-1:0]    r_min_out;
    logic [OUT_W-1:0]    r_max_out;

    logic [63:0]         m64;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         prod_c;
    logic [127:0]        n_acc;
    logic [64:0]         g_sum;
    logic [34:0]         g_q;
    logic [127:0]        m_sum;
    logic [97:0]         m_q;
    logic [MB-1:0]       e_sh;
    logic [EB-1:0]       e_fill;
    logic [EB-1:0]       big_m;
    logic [MB-1:0]       divisor;
    logic [MB-2:0]       hi_part;
    logic [MB:0]         r2;
    logic [MB:0]         diff;
    logic                ge;
    logic [MB:0]         two_m;
    logic [MB+10:0]      g_prod;
    logic [MB+10:0]      g_shr;

    // Shared 32x32 multiplier; its product is registered before any use.
    assign m64 = 64'(r_min);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_GROW: begin
                mul_a = r_growth;
                mul_b = 32'(i_growth_factor);
            end
            MUL_MLO_G: begin
                mul_a = m64[31:0];
                mul_b = r_growth;
            end
            MUL_MHI_G: begin
                mul_a = m64[63:32];
                mul_b = r_growth;
            end
            MUL_MLO_MLO: begin
                mul_a = m64[31:0];
                mul_b = m64[31:0];
            end
            MUL_MLO_MHI: begin
                mul_a = m64[31:0];
                mul_b = m64[63:32];
            end
            MUL_MHI_MHI: begin
                mul_a = m64[63:32];
                mul_b = m64[63:32];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        case (i_cmd.acc_op)
            ACC_HOLD:     n_acc = r_acc;
            ACC_LOAD:     n_acc = 128'(r_prod);
            ACC_ADD_SH32: n_acc = r_acc + (128'(r_prod) << 32);
            ACC_ADD_SH33: n_acc = r_acc + (128'(r_prod) << 33);
            ACC_ADD_SH64: n_acc = r_acc + (128'(r_prod) << 64);
            default:      n_acc = r_acc;
        endcase
    end

    // Round half up by 2^30, then saturate.
    assign g_sum = {1'b0, r_prod} + 65'(Q30_HALF);
    assign g_q   = g_sum[64:30];
    assign m_sum = r_acc + 128'(Q30_HALF);
    assign m_q   = m_sum[127:30];

    assign e_sh   = {r_e, 16'h0000};
    assign e_fill = (r_e != '0) ? r_e : r_fv;

    // Division of the squared minimum by max << 16, one quotient bit a cycle.
    // Only the low MB+1 quotient bits are developed; a larger quotient makes
    // the threshold zero anyway, which r_ovf records.
    assign big_m   = (r_max == '0) ? EB'(1) : r_max;
    assign divisor = {big_m, 16'h0000};
    assign hi_part = r_acc[2*MB-1:MB+1];
    assign r2      = {r_rem, r_quo[MB]};
    assign ge      = (r2 >= {1'b0, divisor});
    assign diff    = r2 - {1'b0, divisor};

    assign two_m  = {r_min, 1'b0};
    assign g_prod = r_t * (MB+11)'(i_threshold_gain);
    assign g_shr  = g_prod >> 16;

    always_comb begin
        n_max    = r_max;
        n_min    = r_min;
        n_growth = r_growth;
        n_fv     = r_fv;
        case (i_cmd.op)
            OP_FIRST: begin
                n_fv     = (r_e != '0) ? r_e : EB'(1);
                n_max    = (r_e != '0) ? r_e : EB'(1);
                n_min    = {((r_e != '0) ? r_e : EB'(1)), 16'h0000};
                n_growth = Q30_ONE;
            end
            OP_GROW: begin
                n_growth = (g_q[34:32] != '0) ? '1 : g_q[31:0];
            end
            OP_MIN: begin
                n_min = ((m_q >> MB) != '0) ? '1 : m_q[MB-1:0];
            end
            OP_CMP: begin
                // A new maximum keeps the growth; anything else restarts it.
                if (r_e > r_max) begin
                    n_max = r_e;
                end else begin
                    n_growth = Q30_ONE;
                    if (e_sh < r_min) begin
                        n_min = {e_fill, 16'h0000};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= EB'(1);
            r_min    <= MB'(32'h0001_0000);
            r_growth <= Q30_ONE;
            r_fv     <= '0;
        end else begin
            r_max    <= n_max;
            r_min    <= n_min;
            r_growth <= n_growth;
            r_fv     <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        r_acc  <= n_acc;
        case (i_cmd.op)
            OP_LOAD_IN: begin
                r_e <= EB'(i_frame_energy);
            end
            OP_DIV_INIT: begin
                r_ovf <= ({1'b0, hi_part} >= divisor);
                r_rem <= {1'b0, hi_part};
                r_quo <= r_acc[MB:0];
            end
            OP_DIV_STEP: begin
                r_rem <= ge ? diff[MB-1:0] : r2[MB-1:0];
                r_quo <= {r_quo[MB-1:0], ge};
            end
            OP_SUB: begin
                r_t <= (r_ovf || (r_quo >= two_m)) ? '0 : (two_m - r_quo);
            end
            OP_GAIN: begin
                r_thr <= ((g_shr >> THR_W) != '0) ? '1 : THR_W'(g_shr);
            end
            OP_OUT: begin
                r_thr_out <= r_thr;
                r_min_out <= OUT_W'(r_min[MB-1:16]);
                r_max_out <= OUT_W'(r_max);
            end
            default: ;
        endcase
    end

    assign o_threshold_out  = r_thr_out;
    assign o_min_energy_out = r_min_out;
    assign o_max_energy_out = r_max_out;

endmodule

`default_nettype wire

// ===== tb/vad_min_max_energy_threshold_test.sv =====
`timescale 1ns / 1ps

module vad_min_max_energy_threshold_test;
    import vmet_pkg::*;

    localparam int ENERGY_BITS   = 32;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 5000;
    localparam int BLOCK_FRAMES  = 160;
    localparam int BLOCKS        = 12;

    localparam logic [63:0]      FLOOR_MAX = (64'd1 << (ENERGY_BITS + 16)) - 64'd1;
    localparam logic [THR_W-1:0] THR_MAX   = '1;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [OUT_W-1:0] floor_level;
        logic [OUT_W-1:0] peak_level;
    } t_vad_result;

    // Tracks Emin/Emax the way the block should and checks each result transfer.
    class threshold_checker;
        logic [GF_W-1:0]          step_factor = GF_RESET;
        logic [GAIN_W-1:0]        gain        = GAIN_RESET;
        logic [ENERGY_BITS-1:0]   peak        = 1;
        logic [ENERGY_BITS+15:0]  floor_q16   = 65536;
        logic [GROWTH_W-1:0]      creep       = Q30_ONE;
        logic [ENERGY_BITS-1:0]   start_level = '0;
        int                       errors      = 0;
        t_vad_result              expected_outputs[$];

        function void load_register(logic idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_GROWTH_FACTOR:  step_factor = value[GF_W-1:0];
                REG_THRESHOLD_GAIN: gain = value[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Product of a value and a Q2.30-scaled factor, rounded half up, saturated to limit.
        function logic [63:0] scale_q30(logic [63:0] a, logic [63:0] b, logic [63:0] limit);
            logic [127:0] p;
            p = a * b + Q30_HALF;
            p = p >> 30;
            return (p > limit) ? limit : p[63:0];
        endfunction

        function logic [THR_W-1:0] detection_level();
            logic [127:0] m, div, q, two_m, p;
            if (gain == 0)
                return '0;
            m   = floor_q16;
            div = (peak == 0) ? 1 : peak;
            if ((m >> 17) >= div)
                return '0;
            q     = (m * m) / (div << 16);
            two_m = m << 1;
            if (q >= two_m)
                return '0;
            p = ((two_m - q) * gain) >> 16;
            return (p > THR_MAX) ? THR_MAX : p[THR_W-1:0];
        endfunction

        function t_vad_result track_frame(logic [ENERGY_BITS-1:0] e, logic first);
            t_vad_result r;
            logic [63:0] v;
            if (first) begin
                start_level = (e != 0) ? e : 1;
                peak        = start_level;
                floor_q16   = {start_level, 16'd0};
            end else begin
                v         = scale_q30(creep, step_factor, 64'hFFFF_FFFF);
                creep     = v[GROWTH_W-1:0];
                v         = scale_q30(floor_q16, creep, FLOOR_MAX);
                floor_q16 = v[ENERGY_BITS+15:0];
            end
            // A new maximum lets the growth keep compounding; anything else restarts it.
            if (e > peak) begin
                peak = e;
            end else if ({e, 16'd0} < floor_q16) begin
                floor_q16 = {((e != 0) ? e : start_level), 16'd0};
                creep     = Q30_ONE;
            end else begin
                creep = Q30_ONE;
            end
            r.threshold   = detection_level();
            r.floor_level = floor_q16[OUT_W+15:16];
            r.peak_level  = peak[OUT_W-1:0];
            return r;
        endfunction

        function void note_frame(logic [IN_W-1:0] energy, logic first);
            expected_outputs.push_back(track_frame(energy[ENERGY_BITS-1:0], first));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_output(logic [THR_W-1:0] thr, logic [OUT_W-1:0] mn,
                                   logic [OUT_W-1:0] mx);
            t_vad_result want;
            if (expected_outputs.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %0d/%0d/%0d",
                         $time, thr, mn, mx);
                errors++;
                return;
            end
            want = expected_outputs.pop_front();
            compare_field("threshold", want.threshold, thr);
            compare_field("min energy", want.floor_level, mn);
            compare_field("max energy", want.peak_level, mx);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic [IN_W-1:0]    i_frame_energy = '0;
    logic               i_first_frame  = 1'b0;
    logic               i_out_ready    = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [ADDR_W-1:0]  paddr          = '0;
    logic [DATA_W-1:0]  pwdata         = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [THR_W-1:0]   o_threshold_out;
    logic [OUT_W-1:0]   o_min_energy_out;
    logic [OUT_W-1:0]   o_max_energy_out;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    threshold_checker sb;
    int               send_idle_pct = 12;
    int               recv_idle_pct = 85;
    logic             hold_request  = 1'b0;
    int               hold_left     = 0;

    vad_min_max_energy_threshold #(
        .ENERGY_BITS(ENERGY_BITS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_frame_energy   (i_frame_energy),
        .i_first_frame    (i_first_frame),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_threshold_out  (o_threshold_out),
        .o_min_energy_out (o_min_energy_out),
        .o_max_energy_out (o_max_energy_out),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offers one frame and returns in the time step of its transfer.
    task automatic send_frame(input logic [IN_W-1:0] energy, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_frame_energy <= energy;
        i_first_frame  <= first;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_frame(energy, first);
    endtask

    task automatic write_register(input logic idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] spare_bits;
        // Bits above the register's width are ignored, so fill them with noise.
        spare_bits = (idx == REG_GROWTH_FACTOR) ? ~DATA_W'({GF_W{1'b1}})
                                                : ~DATA_W'({GAIN_W{1'b1}});
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value | ($urandom() & spare_bits);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.load_register(idx, value);
        // A spell with psel low keeps back-to-back writes apart.
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_outputs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pick_energy();
        logic [63:0]      hi;
        logic [IN_W-1:0]  floor_int;
        floor_int = sb.floor_q16[OUT_W+15:16];
        case ($urandom_range(19))
            0:          return '0;
            1:          return '1;
            2, 3, 4:    return $urandom();
            5, 6:       return $urandom_range(0, 255);
            7, 8, 9, 10: begin
                hi = sb.peak + $urandom_range(1, sb.peak / 16 + 1);
                return (hi > 64'hFFFF_FFFF) ? '1 : hi[IN_W-1:0];
            end
            11, 12, 13, 14, 15:
                        return $urandom_range(floor_int, sb.peak);
            16, 17:     return (floor_int != 0) ? $urandom_range(0, floor_int - 1) : '0;
            default:    return sb.peak - $urandom_range(0, sb.peak / 64);
        endcase
    endfunction

    task automatic run_frames(input int count);
        int   sent;
        int   run_len;
        logic first;
        sent = 0;
        while (sent < count) begin
            run_len = $urandom_range(4, 48);
            for (int k = 0; k < run_len && sent < count; k++) begin
                // A well-formed run opens with a first frame; now and then that
                // frame is missing or a stray one lands in the middle.
                first = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0);
                send_frame(pick_energy(), first);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_output(o_threshold_out, o_min_energy_out, o_max_energy_out);
    end

    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [GF_W-1:0]   factor;
        logic [GAIN_W-1:0] level;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero energy before any first frame leaves the minimum at zero.
        send_frame('0, 1'b0);
        send_frame(32'd5, 1'b0);
        // A zero first frame counts as one.
        send_frame('0, 1'b1);
        send_frame('0, 1'b0);
        send_frame('1, 1'b1);
        send_frame('1, 1'b0);
        send_frame('0, 1'b0);
        send_frame(32'd1000, 1'b1);
        send_frame(32'd2000, 1'b0);
        send_frame(32'd1500, 1'b0);
        send_frame(32'd10, 1'b0);

        // Doubling growth over a run of new maxima pushes Emin above twice Emax.
        settle();
        write_register(REG_GROWTH_FACTOR, DATA_W'({GF_W{1'b1}}));
        write_register(REG_THRESHOLD_GAIN, DATA_W'({GAIN_W{1'b1}}));
        send_frame(32'd3, 1'b1);
        for (int k = 4; k <= 9; k++)
            send_frame(k, 1'b0);
        send_frame('1, 1'b0);
        send_frame('0, 1'b0);

        // Growth factor below 1.0 and a gain of zero.
        settle();
        write_register(REG_GROWTH_FACTOR, '0);
        write_register(REG_THRESHOLD_GAIN, '0);
        send_frame(32'd100, 1'b1);
        send_frame(32'd200, 1'b0);
        send_frame(32'd300, 1'b0);
        send_frame(32'd150, 1'b0);

        for (int blk = 0; blk < BLOCKS; blk++) begin
            settle();
            if (blk == BLOCKS / 3) begin
                send_idle_pct = 85;
                recv_idle_pct = 12;
            end else if (blk == 2 * BLOCKS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (blk == 0) begin
                factor = Q30_ONE[GF_W-1:0];
                level  = 1;
            end else begin
                case ($urandom_range(5))
                    0:       factor = Q30_ONE[GF_W-1:0];
                    1:       factor = '1;
                    2:       factor = Q30_ONE[GF_W-1:0] + GF_W'($urandom_range(0, 1 << 20));
                    3:       factor = GF_W'($urandom());
                    4:       factor = GF_RESET;
                    default: factor = GF_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
                endcase
                case ($urandom_range(4))
                    0:       level = 1;
                    1:       level = '1;
                    2:       level = GAIN_RESET;
                    default: level = GAIN_W'($urandom_range(0, 1023));
                endcase
            end
            write_register(REG_GROWTH_FACTOR, DATA_W'(factor));
            write_register(REG_THRESHOLD_GAIN, DATA_W'(level));
            // Stall the result side long enough for the block to back up its input.
            if (blk == 2 * BLOCKS / 3 + 1)
                hold_request = 1'b1;
            run_frames(BLOCK_FRAMES);
        end
        settle();

        if (sb.errors == 0 && sb.expected_outputs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
